[src/sbaht_pkg.sv]
// Shared constants and types of the swept-box slab hit test unit.
`default_nettype none

package sbaht_pkg;

    // Default widths for the top-level parameters
    localparam int COORD_BITS_DEF     = 21;
    localparam int INV_BITS_DEF       = 32;
    localparam int TIME_FRAC_BITS_DEF = 16;

    // Fixed binary points
    localparam int COORD_FRAC = 4;
    localparam int INV_FRAC   = 16;
    localparam int PROD_FRAC  = COORD_FRAC + INV_FRAC;

    // Times are saturated to +/-2.0 in Q.PROD_FRAC, so sign + 2 integer bits
    localparam int TIME_BITS = PROD_FRAC + 3;

    // Half-extents: three unsigned Q12.4 values packed in one register
    localparam int EXT_BITS  = 16;
    localparam int HEXT_BITS = 3 * EXT_BITS;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_START_Z  = 3'd2,
        REG_INV_X    = 3'd3,
        REG_INV_Y    = 3'd4,
        REG_INV_Z    = 3'd5,
        REG_HALF_EXT = 3'd6
    } cfg_reg_t;

    // Load enables for the per-axis pipeline stages
    typedef struct packed {
        logic ld_prod;
        logic ld_time;
    } stage_ctrl_t;

endpackage : sbaht_pkg

`default_nettype wire

[src/sbaht_cfg_regs.sv]
// Trace configuration registers: start point, inverse direction, half-extents.
`default_nettype none

module sbaht_cfg_regs #(
    parameter int COORD_BITS = sbaht_pkg::COORD_BITS_DEF,
    parameter int INV_BITS   = sbaht_pkg::INV_BITS_DEF,
    parameter int CFG_BITS   = 48
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [sbaht_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire  [CFG_BITS-1:0]                  cfg_wdata,
    output logic signed [COORD_BITS-1:0]         start_x,
    output logic signed [COORD_BITS-1:0]         start_y,
    output logic signed [COORD_BITS-1:0]         start_z,
    output logic signed [INV_BITS-1:0]           inv_x,
    output logic signed [INV_BITS-1:0]           inv_y,
    output logic signed [INV_BITS-1:0]           inv_z,
    output logic [sbaht_pkg::HEXT_BITS-1:0]      half_ext
);
    import sbaht_pkg::*;

    localparam logic [INV_BITS-1:0] INV_MAX = {1'b0, {(INV_BITS-1){1'b1}}};

    logic signed [COORD_BITS-1:0] start_x_reg, start_y_reg, start_z_reg;
    logic signed [INV_BITS-1:0]   inv_x_reg, inv_y_reg, inv_z_reg;
    logic [HEXT_BITS-1:0]         half_ext_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            start_z_reg  <= '0;
            inv_x_reg    <= INV_MAX;
            inv_y_reg    <= INV_MAX;
            inv_z_reg    <= INV_MAX;
            half_ext_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_X:  start_x_reg  <= cfg_wdata[COORD_BITS-1:0];
                REG_START_Y:  start_y_reg  <= cfg_wdata[COORD_BITS-1:0];
                REG_START_Z:  start_z_reg  <= cfg_wdata[COORD_BITS-1:0];
                REG_INV_X:    inv_x_reg    <= cfg_wdata[INV_BITS-1:0];
                REG_INV_Y:    inv_y_reg    <= cfg_wdata[INV_BITS-1:0];
                REG_INV_Z:    inv_z_reg    <= cfg_wdata[INV_BITS-1:0];
                REG_HALF_EXT: half_ext_reg <= cfg_wdata[HEXT_BITS-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign start_x  = start_x_reg;
    assign start_y  = start_y_reg;
    assign start_z  = start_z_reg;
    assign inv_x    = inv_x_reg;
    assign inv_y    = inv_y_reg;
    assign inv_z    = inv_z_reg;
    assign half_ext = half_ext_reg;

endmodule : sbaht_cfg_regs

`default_nettype wire

[src/sbaht_axis_slab.sv]
// One axis of the slab test: plane offsets, scaling, saturation and ordering.
`default_nettype none

module sbaht_axis_slab #(
    parameter int COORD_BITS = sbaht_pkg::COORD_BITS_DEF,
    parameter int INV_BITS   = sbaht_pkg::INV_BITS_DEF
) (
    input  wire                                     aclk,
    input  wire  sbaht_pkg::stage_ctrl_t            ctrl,
    input  wire  signed [COORD_BITS-1:0]            box_min,
    input  wire  signed [COORD_BITS-1:0]            box_max,
    input  wire  signed [COORD_BITS-1:0]            start,
    input  wire  [sbaht_pkg::EXT_BITS-1:0]          ext,
    input  wire  signed [INV_BITS-1:0]              inv,
    output logic signed [sbaht_pkg::TIME_BITS-1:0]  t_lo,
    output logic signed [sbaht_pkg::TIME_BITS-1:0]  t_hi
);
    import sbaht_pkg::*;

    // Offset width: coordinate span plus extent, with headroom for two subtractions
    localparam int OFS_BITS  = ((COORD_BITS > EXT_BITS + 1) ? COORD_BITS : EXT_BITS + 1) + 2;
    localparam int PROD_BITS = OFS_BITS + INV_BITS;
    localparam logic signed [PROD_BITS-1:0] T_LIM  = PROD_BITS'(64'd1 << (PROD_FRAC + 1));
    localparam logic signed [PROD_BITS-1:0] T_NLIM = -T_LIM;

    logic signed [OFS_BITS-1:0]  ofs_lo, ofs_hi;
    logic signed [PROD_BITS-1:0] prod_lo_next, prod_hi_next;
    logic signed [PROD_BITS-1:0] prod_lo_reg, prod_hi_reg;
    logic signed [TIME_BITS-1:0] sat_lo, sat_hi;
    logic signed [TIME_BITS-1:0] t_lo_next, t_hi_next;
    logic signed [TIME_BITS-1:0] t_lo_reg, t_hi_reg;

    // Box shifted by the start point and grown by the extent on both sides
    assign ofs_lo = OFS_BITS'(box_min) - OFS_BITS'(start)
                  - $signed({{(OFS_BITS-EXT_BITS){1'b0}}, ext});
    assign ofs_hi = OFS_BITS'(box_max) - OFS_BITS'(start)
                  + $signed({{(OFS_BITS-EXT_BITS){1'b0}}, ext});

    assign prod_lo_next = PROD_BITS'(ofs_lo) * PROD_BITS'(inv);
    assign prod_hi_next = PROD_BITS'(ofs_hi) * PROD_BITS'(inv);

    always_ff @(posedge aclk) begin
        if (ctrl.ld_prod) begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
        end
    end

    // Clip to +/-2.0; beyond that the slab decision cannot change
    always_comb begin
        priority if (prod_lo_reg > T_LIM)       sat_lo = TIME_BITS'(T_LIM);
        else if (prod_lo_reg < T_NLIM)          sat_lo = TIME_BITS'(T_NLIM);
        else                                    sat_lo = TIME_BITS'(prod_lo_reg);
        priority if (prod_hi_reg > T_LIM)       sat_hi = TIME_BITS'(T_LIM);
        else if (prod_hi_reg < T_NLIM)          sat_hi = TIME_BITS'(T_NLIM);
        else                                    sat_hi = TIME_BITS'(prod_hi_reg);
    end

    // Negative direction swaps the planes
    assign t_lo_next = (sat_lo < sat_hi) ? sat_lo : sat_hi;
    assign t_hi_next = (sat_lo < sat_hi) ? sat_hi : sat_lo;

    always_ff @(posedge aclk) begin
        if (ctrl.ld_time) begin
            t_lo_reg <= t_lo_next;
            t_hi_reg <= t_hi_next;
        end
    end

    assign t_lo = t_lo_reg;
    assign t_hi = t_hi_reg;

endmodule : sbaht_axis_slab

`default_nettype wire

[src/swept_box_aabb_hit_test_unit.sv]
// Top level: swept-box trace vs axis-aligned box slab test, one box per cycle unless stalled.
// Registers from input transaction to result valid: input, product, axis time, result.
// Throughput: one transaction per cycle unless stalled; each stage holds on its own
//   when the result side stalls; bubbles squeeze out, input flows until all stages fill.
// Reset (aresetn, synchronous, active low): pipeline empty, start and extents 0,
//   inverse direction max positive; payload registers are not reset.
`default_nettype none

module swept_box_aabb_hit_test_unit #(
    parameter int COORD_BITS     = sbaht_pkg::COORD_BITS_DEF,
    parameter int INV_BITS       = sbaht_pkg::INV_BITS_DEF,
    parameter int TIME_FRAC_BITS = sbaht_pkg::TIME_FRAC_BITS_DEF,
    parameter int CFG_BITS       = (INV_BITS > sbaht_pkg::HEXT_BITS) ?
                                   INV_BITS : sbaht_pkg::HEXT_BITS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration write port
    input  wire                                 cfg_wr_en,
    input  wire  [sbaht_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire  [CFG_BITS-1:0]                 cfg_wdata,
    // box channel
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  signed [COORD_BITS-1:0]        s_box_min_x,
    input  wire  signed [COORD_BITS-1:0]        s_box_min_y,
    input  wire  signed [COORD_BITS-1:0]        s_box_min_z,
    input  wire  signed [COORD_BITS-1:0]        s_box_max_x,
    input  wire  signed [COORD_BITS-1:0]        s_box_max_y,
    input  wire  signed [COORD_BITS-1:0]        s_box_max_z,
    // result channel
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic                                m_hit,
    output logic [TIME_FRAC_BITS:0]             m_entry_frac
);
    import sbaht_pkg::*;

    // Padding so the Q.PROD_FRAC -> Q.TIME_FRAC_BITS rescale is one part-select
    // for fraction widths either side of PROD_FRAC.
    localparam int FRAC_PAD = 24;
    localparam int SEL_LSB  = PROD_FRAC + FRAC_PAD - TIME_FRAC_BITS;
    localparam logic signed [TIME_BITS-1:0] T_ONE = TIME_BITS'(64'd1 << PROD_FRAC);

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] start_x, start_y, start_z;
    logic signed [INV_BITS-1:0]   inv_x, inv_y, inv_z;
    logic [HEXT_BITS-1:0]         half_ext;

    sbaht_cfg_regs #(
        .COORD_BITS (COORD_BITS),
        .INV_BITS   (INV_BITS),
        .CFG_BITS   (CFG_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .inv_x     (inv_x),
        .inv_y     (inv_y),
        .inv_z     (inv_z),
        .half_ext  (half_ext)
    );

    // ---------------------------------------------------------------------
    // Pipeline control: each stage loads when empty or when its successor
    // frees up in the same cycle.
    // ---------------------------------------------------------------------
    logic        in_vld_reg, prod_vld_reg, time_vld_reg, out_vld_reg;
    logic        rdy_out, rdy_time, rdy_prod, rdy_in;
    stage_ctrl_t axis_ctrl;

    assign rdy_out  = !out_vld_reg  || m_ready;
    assign rdy_time = !time_vld_reg || rdy_out;
    assign rdy_prod = !prod_vld_reg || rdy_time;
    assign rdy_in   = !in_vld_reg   || rdy_prod;
    assign s_ready  = rdy_in;

    assign axis_ctrl = '{ld_prod: rdy_prod, ld_time: rdy_time};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            time_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (rdy_in)   in_vld_reg   <= s_valid;
            if (rdy_prod) prod_vld_reg <= in_vld_reg;
            if (rdy_time) time_vld_reg <= prod_vld_reg;
            if (rdy_out)  out_vld_reg  <= time_vld_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] bmin_x_reg, bmin_y_reg, bmin_z_reg;
    logic signed [COORD_BITS-1:0] bmax_x_reg, bmax_y_reg, bmax_z_reg;

    always_ff @(posedge aclk) begin
        if (rdy_in && s_valid) begin
            bmin_x_reg <= s_box_min_x;
            bmin_y_reg <= s_box_min_y;
            bmin_z_reg <= s_box_min_z;
            bmax_x_reg <= s_box_max_x;
            bmax_y_reg <= s_box_max_y;
            bmax_z_reg <= s_box_max_z;
        end
    end

    // ---------------------------------------------------------------------
    // Per-axis slab times (two stages inside each lane)
    // ---------------------------------------------------------------------
    logic signed [TIME_BITS-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;

    sbaht_axis_slab #(.COORD_BITS(COORD_BITS), .INV_BITS(INV_BITS)) u_axis_x (
        .aclk    (aclk),
        .ctrl    (axis_ctrl),
        .box_min (bmin_x_reg),
        .box_max (bmax_x_reg),
        .start   (start_x),
        .ext     (half_ext[EXT_BITS-1:0]),
        .inv     (inv_x),
        .t_lo    (lo_x),
        .t_hi    (hi_x)
    );

    sbaht_axis_slab #(.COORD_BITS(COORD_BITS), .INV_BITS(INV_BITS)) u_axis_y (
        .aclk    (aclk),
        .ctrl    (axis_ctrl),
        .box_min (bmin_y_reg),
        .box_max (bmax_y_reg),
        .start   (start_y),
        .ext     (half_ext[2*EXT_BITS-1:EXT_BITS]),
        .inv     (inv_y),
        .t_lo    (lo_y),
        .t_hi    (hi_y)
    );

    sbaht_axis_slab #(.COORD_BITS(COORD_BITS), .INV_BITS(INV_BITS)) u_axis_z (
        .aclk    (aclk),
        .ctrl    (axis_ctrl),
        .box_min (bmin_z_reg),
        .box_max (bmax_z_reg),
        .start   (start_z),
        .ext     (half_ext[3*EXT_BITS-1:2*EXT_BITS]),
        .inv     (inv_z),
        .t_lo    (lo_z),
        .t_hi    (hi_z)
    );

    // ---------------------------------------------------------------------
    // Reduction: latest entry, earliest exit, clamp to [0, 1], compare
    // ---------------------------------------------------------------------
    logic signed [TIME_BITS-1:0]    entry_xy, entry_all, exit_xy, exit_all;
    logic signed [TIME_BITS-1:0]    entry_clamp, exit_clamp;
    logic [TIME_BITS+FRAC_PAD-1:0]  entry_wide;
    logic                           hit_next;
    logic [TIME_FRAC_BITS:0]        frac_next;
    logic                           hit_reg;
    logic [TIME_FRAC_BITS:0]        frac_reg;

    assign entry_xy  = (lo_y > lo_x) ? lo_y : lo_x;
    assign entry_all = (lo_z > entry_xy) ? lo_z : entry_xy;
    assign exit_xy   = (hi_y < hi_x) ? hi_y : hi_x;
    assign exit_all  = (hi_z < exit_xy) ? hi_z : exit_xy;

    assign entry_clamp = (entry_all < 0) ? '0 : entry_all;
    assign exit_clamp  = (exit_all > T_ONE) ? T_ONE : exit_all;

    assign hit_next   = (entry_clamp <= exit_clamp);
    // Entry is non-negative here, so truncation is a plain bit select
    assign entry_wide = {entry_clamp, {FRAC_PAD{1'b0}}};
    assign frac_next  = hit_next ? entry_wide[SEL_LSB +: TIME_FRAC_BITS+1] : '0;

    always_ff @(posedge aclk) begin
        if (rdy_out && time_vld_reg) begin
            hit_reg  <= hit_next;
            frac_reg <= frac_next;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_hit        = hit_reg;
    assign m_entry_frac = frac_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_vld_reg && !prod_vld_reg && !time_vld_reg && !out_vld_reg) |-> s_ready)
        else $error("empty pipeline refuses a transaction");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_vld_reg)
        else $error("accepted transaction not held in input stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (time_vld_reg && out_vld_reg && !m_ready) |=> time_vld_reg)
        else $error("axis stage dropped while result stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_entry_frac == '0))
        else $error("miss carries non-zero fraction");

    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (m_entry_frac <= ((TIME_FRAC_BITS+1)'(1) << TIME_FRAC_BITS)))
        else $error("entry fraction above 1.0");

endmodule : swept_box_aabb_hit_test_unit

`default_nettype wire

[bench/swept_box_aabb_hit_test_unit_test.sv]
// Self-checking bench for the swept-box slab hit test unit: box stream in, hit verdicts out.
`default_nettype none

module swept_box_aabb_hit_test_unit_test;

    import sbaht_pkg::*;

    localparam int CB    = COORD_BITS_DEF;
    localparam int TFB   = TIME_FRAC_BITS_DEF;
    localparam int CFG_W = (INV_BITS_DEF > HEXT_BITS) ? INV_BITS_DEF : HEXT_BITS;

    // Times are Q.PROD_FRAC; products saturate to +/-2.0, exit clamps to 1.0
    localparam longint T_ONE = longint'(1) <<< PROD_FRAC;
    localparam longint T_LIM = longint'(1) <<< (PROD_FRAC + 1);

    // Index 7 has no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

    localparam int HOLD_CYCLES    = 90;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BOXES    = 150;

    // One box transaction: corners per axis, index 0 = x, 1 = y, 2 = z
    typedef struct packed {
        logic [2:0][CB-1:0] lo;
        logic [2:0][CB-1:0] hi;
    } box_t;

    typedef struct packed {
        logic         hit;
        logic [TFB:0] fraction;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_W-1:0]        cfg_wdata;

    logic                 s_valid;
    logic                 s_ready;
    logic signed [CB-1:0] s_box_min_x, s_box_min_y, s_box_min_z;
    logic signed [CB-1:0] s_box_max_x, s_box_max_y, s_box_max_z;

    logic         m_valid;
    logic         m_ready;
    logic         m_hit;
    logic [TFB:0] m_entry_frac;

    // Bench copy of the trace registers, updated as each write is issued
    logic signed [CB-1:0]           trc_start [3];
    logic signed [INV_BITS_DEF-1:0] trc_inv   [3];
    logic [HEXT_BITS-1:0]           trc_ext;

    // Per-axis trace delta (Q.4): aims boxes along the trace and sets random-trace inverses
    int gen_delta [3];

    box_t     boxes_pending [$];   // boxes still to be offered
    verdict_t hits_due      [$];   // verdicts of accepted boxes, oldest first
    box_t     box_on_wire;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;                  // toggled to ask the receiver for a long hold-off
    int faults;
    int quiet;

    swept_box_aabb_hit_test_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_box_min_x    (s_box_min_x),
        .s_box_min_y    (s_box_min_y),
        .s_box_min_z    (s_box_min_z),
        .s_box_max_x    (s_box_max_x),
        .s_box_max_y    (s_box_max_y),
        .s_box_max_z    (s_box_max_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_entry_frac   (m_entry_frac)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // Plane offset (Q.4) times inverse direction (Q.16), saturated to +/-2.0.
    // Operands stay below 2^22 and 2^31, so the full product fits in 64 bits.
    function automatic longint sat_time(longint offset, longint inv);
        longint p;
        p = offset * inv;
        if (p > T_LIM) p = T_LIM;
        if (p < -T_LIM) p = -T_LIM;
        return p;
    endfunction

    function automatic verdict_t slab_verdict(box_t b);
        longint t0, t1, near_t, far_t, entry, leave, ext;
        verdict_t v;
        // saturated times never leave [-T_LIM, T_LIM], so these seeds are neutral
        entry = -T_LIM;
        leave = T_LIM;
        for (int a = 0; a < 3; a++) begin
            ext    = longint'(trc_ext[a*EXT_BITS +: EXT_BITS]);
            t0     = sat_time($signed(b.lo[a]) - trc_start[a] - ext, trc_inv[a]);
            t1     = sat_time($signed(b.hi[a]) - trc_start[a] + ext, trc_inv[a]);
            // min/max per axis also sorts out inverted corners and negative directions
            near_t = (t0 < t1) ? t0 : t1;
            far_t  = (t0 < t1) ? t1 : t0;
            if (near_t > entry) entry = near_t;
            if (far_t < leave) leave = far_t;
        end
        if (entry < 0) entry = 0;
        if (leave > T_ONE) leave = T_ONE;
        v.hit      = (entry <= leave);
        v.fraction = v.hit ? (TFB+1)'(entry >>> (PROD_FRAC - TFB)) : '0;
        return v;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [CB-1:0] fit(longint v);
        longint top, bot;
        top = (longint'(1) <<< (CB - 1)) - 1;
        bot = -(longint'(1) <<< (CB - 1));
        if (v > top) v = top;
        if (v < bot) v = bot;
        return v[CB-1:0];
    endfunction

    function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
        box_t b;
        b.lo[0] = fit(lx); b.lo[1] = fit(ly); b.lo[2] = fit(lz);
        b.hi[0] = fit(hx); b.hi[1] = fit(hy); b.hi[2] = fit(hz);
        return b;
    endfunction

    // Mostly boxes placed around a point on the trace (so hits and near misses
    // are common), some with a swapped axis, the rest raw bit noise.
    function automatic box_t fresh_box();
        logic [127:0] raw;
        box_t   b;
        int     kind, t, jit, a;
        logic [CB-1:0] tmp;
        longint c;
        kind = $urandom_range(99);
        if (kind < 15) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            b   = raw[$bits(box_t)-1:0];
            return b;
        end
        t = int'($urandom_range(358)) - 51;          // -0.2 .. 1.2 in 1/256 steps
        for (a = 0; a < 3; a++) begin
            jit   = 1 << $urandom_range(12);
            c     = trc_start[a] + (longint'(gen_delta[a]) * t) / 256
                    + int'($urandom_range(2 * jit)) - jit;
            b.lo[a] = fit(c - int'($urandom_range(1 << $urandom_range(14))));
            b.hi[a] = fit(c + int'($urandom_range(1 << $urandom_range(14))));
        end
        if (kind < 25) begin
            a       = $urandom_range(2);
            tmp     = b.lo[a];
            b.lo[a] = b.hi[a];
            b.hi[a] = tmp;
        end
        return b;
    endfunction

    function automatic int inv_of(int d);
        if (d == 0) return 32'h7fff_ffff;
        return (1 << (COORD_FRAC + INV_FRAC)) / d;
    endfunction

    // One register write; the bench copy follows the same masking rules
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_START_X:  trc_start[0] = data[CB-1:0];
            REG_START_Y:  trc_start[1] = data[CB-1:0];
            REG_START_Z:  trc_start[2] = data[CB-1:0];
            REG_INV_X:    trc_inv[0]   = data[INV_BITS_DEF-1:0];
            REG_INV_Y:    trc_inv[1]   = data[INV_BITS_DEF-1:0];
            REG_INV_Z:    trc_inv[2]   = data[INV_BITS_DEF-1:0];
            REG_HALF_EXT: trc_ext      = data[HEXT_BITS-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Loads the whole trace, with junk above each register narrower than the write word,
    // plus a write to the unused index. Only called with the pipeline drained.
    task automatic set_trace(input int sx, input int sy, input int sz,
                             input int ix, input int iy, input int iz,
                             input logic [HEXT_BITS-1:0] ext);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_START_X, {junk[CFG_W-1:CB], sx[CB-1:0]});
        write_reg(REG_START_Y, {junk[CFG_W-CB-1:0], sy[CB-1:0]});
        write_reg(REG_START_Z, {junk[CFG_W+7:CB+8], sz[CB-1:0]});
        write_reg(REG_INV_X, {junk[CFG_W-INV_BITS_DEF-1:0], ix});
        write_reg(REG_INV_Y, {junk[CFG_W-1:INV_BITS_DEF], iy});
        write_reg(REG_INV_Z, {junk[CFG_W+15:INV_BITS_DEF+16], iz});
        write_reg(REG_SPARE, CFG_W'({$urandom, $urandom}));
        write_reg(REG_HALF_EXT, ext);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_trace();
        int s [3];
        logic [HEXT_BITS-1:0] ext;
        for (int a = 0; a < 3; a++) begin
            gen_delta[a] = ($urandom_range(3) == 0) ? 0 :
                           int'($urandom_range(2 << 18)) - (1 << 18);
            gen_delta[a] = gen_delta[a] >>> $urandom_range(18);
            s[a]         = int'($urandom_range(1 << 20)) - (1 << 19);
            ext[a*EXT_BITS +: EXT_BITS] = EXT_BITS'($urandom_range(1 << $urandom_range(12)));
        end
        set_trace(s[0], s[1], s[2],
                  inv_of(gen_delta[0]), inv_of(gen_delta[1]), inv_of(gen_delta[2]), ext);
    endtask

    // Sequence waits until every box is sent and every outstanding verdict has come out
    task automatic wait_drained();
        do @(posedge aclk);
        while (boxes_pending.size() != 0 || s_valid || hits_due.size() != 0);
    endtask

    // ---------------------------------------------------------------------
    // Box channel driver: offers the next pending box, holds it until taken
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // a transaction just completed: predict its verdict under the current trace
            if (s_valid) hits_due.push_back(slab_verdict(box_on_wire));
            if (boxes_pending.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
                box_on_wire = boxes_pending.pop_front();
                s_valid     <= 1'b1;
                s_box_min_x <= box_on_wire.lo[0];
                s_box_min_y <= box_on_wire.lo[1];
                s_box_min_z <= box_on_wire.lo[2];
                s_box_max_x <= box_on_wire.hi[0];
                s_box_max_y <= box_on_wire.hi[1];
                s_box_max_z <= box_on_wire.hi[2];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result channel monitor: checks each verdict and randomises ready
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : collect
        verdict_t want;
        bit       hold_seen;
        int       hold_left;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected result transaction, hit %0b fraction %0d",
                             $time, m_hit, m_entry_frac);
                    faults++;
                end else begin
                    want = hits_due.pop_front();
                    if (m_hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0b got %0b",
                                 $time, want.hit, m_hit);
                        faults++;
                    end
                    if (m_entry_frac !== want.fraction) begin
                        $display("%0t: entry_frac mismatch, expected %0d got %0d",
                                 $time, want.fraction, m_entry_frac);
                        faults++;
                    end
                end
            end
            // long hold-off, counted here, so the pipeline fills and s_ready drops
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("swept_box_aabb_hit_test_unit regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence: reset, directed boxes over a few traces, then random phases
    // ---------------------------------------------------------------------
    initial begin
        int mx, mn;
        mx = (1 << (CB - 1)) - 1;
        mn = -(1 << (CB - 1));

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        hold_req    = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 74;
        // register state after reset
        for (int a = 0; a < 3; a++) begin
            trc_start[a] = '0;
            trc_inv[a]   = 32'h7fff_ffff;
            gen_delta[a] = 0;
        end
        trc_ext = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset trace: zero-length sweep at the origin
        boxes_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));        // touching, entry == exit
        boxes_pending.push_back(mk_box(1, 1, 1, 2, 2, 2));        // ahead, saturates past 1.0
        boxes_pending.push_back(mk_box(-2, -2, -2, -1, -1, -1));  // behind
        boxes_pending.push_back(mk_box(-1, -1, -1, 1, 1, 1));     // encloses the start
        wait_drained();

        // Unit sweep along (1,1,1) world units: exact fractions
        set_trace(0, 0, 0, inv_of(16), inv_of(16), inv_of(16), '0);
        boxes_pending.push_back(mk_box(16, 16, 16, 40, 40, 40));  // entry exactly 1.0
        boxes_pending.push_back(mk_box(17, 17, 17, 40, 40, 40));  // just past the end
        boxes_pending.push_back(mk_box(8, 8, 8, 9, 9, 9));        // entry 0.5
        boxes_pending.push_back(mk_box(9, 9, 9, 8, 8, 8));        // same box, corners swapped
        boxes_pending.push_back(mk_box(-40, -40, -40, -20, -20, -20));
        boxes_pending.push_back(mk_box(-5, -5, -5, 5, 5, 5));
        boxes_pending.push_back(mk_box(mn, mn, mn, mx, mx, mx));  // whole world
        boxes_pending.push_back(mk_box(mx, mx, mx, mn, mn, mn));  // whole world, inverted
        boxes_pending.push_back(mk_box(mx, mx, mx, mx, mx, mx));
        boxes_pending.push_back(mk_box(mn, mn, mn, mn, mn, mn));
        boxes_pending.push_back(mk_box(8, 4, 2, 12, 20, 6));      // axes disagree
        wait_drained();

        // Extreme registers: corner starts, extreme and zero inverse, widest extents
        set_trace(mn, mx, 0, 32'h8000_0000, 32'h7fff_ffff, 0, {HEXT_BITS{1'b1}});
        boxes_pending.push_back(mk_box(mn, mn, mn, mx, mx, mx));
        boxes_pending.push_back(mk_box(mx, mn, 0, mx, mn, 0));
        boxes_pending.push_back(mk_box(mn, mx, mx, mn, mx, mn));
        boxes_pending.push_back(mk_box(0, 0, 0, 0, 0, 0));
        boxes_pending.push_back(mk_box(mx, mx, -1, mn, mn, 1));
        wait_drained();

        // Random part: first three phases sender 30 / receiver 74 percent idle,
        // the next three the reverse, then no idling at all
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 30;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 2) begin
                for (int a = 0; a < 3; a++) gen_delta[a] = 0;
                set_trace(mx, mn, mx, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          {HEXT_BITS{1'b1}});
            end else if (p == 5) begin
                for (int a = 0; a < 3; a++) gen_delta[a] = 0;
                set_trace(mn, mn, mn, 1, -1, 0, '0);
            end else if (p == 6) begin
                // stationary trace: every axis delta zero, so a plain point test
                for (int a = 0; a < 3; a++) gen_delta[a] = 0;
                set_trace(int'($urandom_range(1 << 16)), -int'($urandom_range(1 << 16)), 0,
                          inv_of(0), inv_of(0), inv_of(0), '0);
            end else begin
                random_trace();
            end
            if (p == 1 || p == 7) hold_req = ~hold_req;
            for (int n = 0; n < PHASE_BOXES; n++) boxes_pending.push_back(fresh_box());
            wait_drained();
        end

        // latency tail: nothing further may come out
        repeat (8) @(posedge aclk);
        if (faults == 0 && hits_due.size() == 0) begin
            $display("swept_box_aabb_hit_test_unit regression: pass");
        end else begin
            $display("swept_box_aabb_hit_test_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/sbaht_pkg.sv
src/sbaht_cfg_regs.sv
src/sbaht_axis_slab.sv
src/swept_box_aabb_hit_test_unit.sv
bench/swept_box_aabb_hit_test_unit_test.sv
